// File: design/mfek_pkg.sv
package mfek_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VID_W        = 4;
    localparam int SLOTS        = MAX_VERTICES * MAX_VERTICES;
    localparam int SLOT_W       = 2 * VID_W;
    localparam int CAP_BITS     = 20;
    localparam int RES_BITS     = CAP_BITS + 1;
    localparam int COST_BITS    = 16;
    localparam int PROD_BITS    = CAP_BITS + COST_BITS;
    localparam int FLOW_BITS    = 24;
    localparam int CSUM_BITS    = 54;
    localparam int AVG_BITS     = 28;
    localparam int FRAC_BITS    = 8;
    localparam int DVD_BITS     = CSUM_BITS + FRAC_BITS;
    localparam int DCNT_W       = 6;
    localparam int NV_W         = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    localparam logic [CAP_BITS-1:0]  PATH_CAP  = CAP_BITS'(1000000);
    localparam logic [FLOW_BITS-1:0] FLOW_MAX  = '1;
    localparam logic [CSUM_BITS-1:0] CSUM_MAX  = '1;
    localparam logic [AVG_BITS-1:0]  AVG_MAX   = '1;
    localparam logic [NV_W-1:0]      NV_MAX    = NV_W'(MAX_VERTICES);
    localparam logic [DCNT_W-1:0]    DIV_STEPS = DCNT_W'(DVD_BITS);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_NODE    = 2'd2;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_ZERO_FLOW    = 2'd1;
    localparam logic [1:0] STATUS_ANTIPARALLEL = 2'd2;

    typedef struct packed {
        logic [VID_W-1:0]     from_node;
        logic [VID_W-1:0]     to_node;
        logic [CAP_BITS-1:0]  edge_capacity;
        logic [COST_BITS-1:0] unit_cost;
        logic                 last_edge;
    } in_word_t;

    typedef struct packed {
        logic [FLOW_BITS-1:0] total_flow;
        logic [CSUM_BITS-1:0] total_cost;
        logic [AVG_BITS-1:0]  avg_cost;
        logic [1:0]           status;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_COPY, S_COPY_TAIL, S_BFS_INIT, S_BFS_POP, S_BFS_SCAN, S_BFS_TAIL,
        S_BN_INIT, S_BN_RD, S_BN_CMP, S_AUG_INIT, S_AUG_RD, S_AUG_SUB, S_AUG_ADD,
        S_AUG_DONE, S_REC_A, S_REC_B, S_REC_C, S_REC_D, S_DIV_INIT, S_DIV, S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic copy_rd;
        logic bfs_init;
        logic pop;
        logic scan_issue;
        logic bn_init;
        logic bn_cmp;
        logic aug_init;
        logic aug_sub;
        logic aug_add;
        logic aug_done;
        logic rec_a;
        logic rec_b;
        logic rec_c;
        logic rec_d;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cp_last;
        logic terms_ok;
        logic n_zero;
        logic q_empty;
        logic scan_last;
        logic sink_found;
        logic path_done;
        logic rec_last;
        logic flow_zero;
        logic div_last;
        logic out_free;
    } stat_t;

endpackage

// File: design/mfek_ram.sv
module mfek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mfek_ctrl.sv
module mfek_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last,
    input  mfek_pkg::stat_t  stat,
    output mfek_pkg::cmd_t   cmd,
    output logic             s_ready
);

    mfek_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfek_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mfek_pkg::S_IDLE:      if (s_valid && s_last) state_next = mfek_pkg::S_COPY;
            mfek_pkg::S_COPY:      if (stat.cp_last) state_next = mfek_pkg::S_COPY_TAIL;
            mfek_pkg::S_COPY_TAIL: begin
                if (stat.terms_ok)    state_next = mfek_pkg::S_BFS_INIT;
                else if (stat.n_zero) state_next = mfek_pkg::S_DIV_INIT;
                else                  state_next = mfek_pkg::S_REC_A;
            end
            mfek_pkg::S_BFS_INIT:  state_next = mfek_pkg::S_BFS_POP;
            mfek_pkg::S_BFS_POP: begin
                if (!stat.q_empty)       state_next = mfek_pkg::S_BFS_SCAN;
                else if (stat.sink_found) state_next = mfek_pkg::S_BN_INIT;
                else                     state_next = mfek_pkg::S_REC_A;
            end
            mfek_pkg::S_BFS_SCAN:  if (stat.scan_last) state_next = mfek_pkg::S_BFS_TAIL;
            mfek_pkg::S_BFS_TAIL:  state_next = mfek_pkg::S_BFS_POP;
            mfek_pkg::S_BN_INIT:   state_next = mfek_pkg::S_BN_RD;
            mfek_pkg::S_BN_RD: begin
                state_next = stat.path_done ? mfek_pkg::S_AUG_INIT : mfek_pkg::S_BN_CMP;
            end
            mfek_pkg::S_BN_CMP:    state_next = mfek_pkg::S_BN_RD;
            mfek_pkg::S_AUG_INIT:  state_next = mfek_pkg::S_AUG_RD;
            mfek_pkg::S_AUG_RD: begin
                state_next = stat.path_done ? mfek_pkg::S_AUG_DONE : mfek_pkg::S_AUG_SUB;
            end
            mfek_pkg::S_AUG_SUB:   state_next = mfek_pkg::S_AUG_ADD;
            mfek_pkg::S_AUG_ADD:   state_next = mfek_pkg::S_AUG_RD;
            mfek_pkg::S_AUG_DONE:  state_next = mfek_pkg::S_BFS_INIT;
            mfek_pkg::S_REC_A:     state_next = mfek_pkg::S_REC_B;
            mfek_pkg::S_REC_B:     state_next = mfek_pkg::S_REC_C;
            mfek_pkg::S_REC_C:     state_next = mfek_pkg::S_REC_D;
            mfek_pkg::S_REC_D: begin
                state_next = stat.rec_last ? mfek_pkg::S_DIV_INIT : mfek_pkg::S_REC_A;
            end
            mfek_pkg::S_DIV_INIT: begin
                state_next = stat.flow_zero ? mfek_pkg::S_OUT : mfek_pkg::S_DIV;
            end
            mfek_pkg::S_DIV:       if (stat.div_last) state_next = mfek_pkg::S_OUT;
            mfek_pkg::S_OUT:       if (stat.out_free) state_next = mfek_pkg::S_IDLE;
            default:               state_next = mfek_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            mfek_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            mfek_pkg::S_COPY:     cmd.copy_rd    = 1'b1;
            mfek_pkg::S_BFS_INIT: cmd.bfs_init   = 1'b1;
            mfek_pkg::S_BFS_POP:  cmd.pop        = !stat.q_empty;
            mfek_pkg::S_BFS_SCAN: cmd.scan_issue = 1'b1;
            mfek_pkg::S_BN_INIT:  cmd.bn_init    = 1'b1;
            mfek_pkg::S_BN_CMP:   cmd.bn_cmp     = 1'b1;
            mfek_pkg::S_AUG_INIT: cmd.aug_init   = 1'b1;
            mfek_pkg::S_AUG_SUB:  cmd.aug_sub    = 1'b1;
            mfek_pkg::S_AUG_ADD:  cmd.aug_add    = 1'b1;
            mfek_pkg::S_AUG_DONE: cmd.aug_done   = 1'b1;
            mfek_pkg::S_REC_A:    cmd.rec_a      = 1'b1;
            mfek_pkg::S_REC_B:    cmd.rec_b      = 1'b1;
            mfek_pkg::S_REC_C:    cmd.rec_c      = 1'b1;
            mfek_pkg::S_REC_D:    cmd.rec_d      = 1'b1;
            mfek_pkg::S_DIV_INIT: cmd.div_init   = 1'b1;
            mfek_pkg::S_DIV:      cmd.div_step   = 1'b1;
            mfek_pkg::S_OUT:      cmd.out_load   = stat.out_free;
            default:              cmd            = '0;
        endcase
    end

endmodule

// File: design/mfek_dp.sv
module mfek_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mfek_pkg::cmd_t                      cmd,
    output mfek_pkg::stat_t                     stat,
    input  mfek_pkg::in_word_t                  s_data,
    input  logic                                cfg_wr_en,
    input  logic [mfek_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfek_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mfek_pkg::out_word_t                 m_data
);

    localparam int VW = mfek_pkg::VID_W;

    // configuration
    logic [mfek_pkg::NV_W-1:0] nv_reg;
    logic [VW-1:0]             src_reg, snk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg  <= mfek_pkg::NV_MAX;
            src_reg <= '0;
            snk_reg <= VW'(15);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mfek_pkg::CFG_NUM_VERTICES: nv_reg  <= cfg_wdata;
                mfek_pkg::CFG_SOURCE_NODE:  src_reg <= cfg_wdata[VW-1:0];
                mfek_pkg::CFG_SINK_NODE:    snk_reg <= cfg_wdata[VW-1:0];
                default: ;
            endcase
        end
    end

    logic [mfek_pkg::NV_W-1:0] n_eff;
    logic [VW-1:0]             n_m1;
    assign n_eff = (nv_reg > mfek_pkg::NV_MAX) ? mfek_pkg::NV_MAX : nv_reg;
    assign n_m1  = VW'(n_eff - 1'b1);

    // slot valid bits: an invalid slot reads as zero capacity and cost
    logic [mfek_pkg::SLOTS-1:0] valid_reg;

    logic [mfek_pkg::SLOT_W-1:0]    cap_raddr, cap_waddr;
    logic [mfek_pkg::CAP_BITS-1:0]  cap_q, cap_eff;
    logic [mfek_pkg::COST_BITS-1:0] cost_q, cost_eff;
    logic                           cap_v_reg;

    logic [mfek_pkg::SLOT_W-1:0]   res_raddr, res_waddr;
    logic [mfek_pkg::RES_BITS-1:0] res_q, res_wdata;
    logic                          res_we;

    // copy sweep
    logic [mfek_pkg::SLOT_W-1:0] cp_reg, cp_d_reg;
    logic                        cp_pend_reg;

    // search
    logic [VW-1:0]               queue_reg  [mfek_pkg::MAX_VERTICES];
    logic [VW-1:0]               parent_reg [mfek_pkg::MAX_VERTICES];
    logic [mfek_pkg::MAX_VERTICES-1:0] visited_reg;
    logic [VW:0]                 head_reg, tail_reg;
    logic [VW-1:0]               u_reg, sv_reg, pv_reg;
    logic                        pend_reg;

    // path walk
    logic [VW-1:0]                 w_reg, par_w;
    logic [mfek_pkg::CAP_BITS-1:0] bn_reg;
    logic [mfek_pkg::FLOW_BITS-1:0] flow_reg;
    logic [mfek_pkg::FLOW_BITS:0]   flow_sum;

    // recovery
    logic [VW-1:0]                  ru_reg, rv_reg;
    logic [mfek_pkg::CAP_BITS-1:0]  c_reg, f_val;
    logic [mfek_pkg::COST_BITS-1:0] uc_reg;
    logic [mfek_pkg::RES_BITS-1:0]  r_reg;
    logic [mfek_pkg::PROD_BITS-1:0] prod_reg;
    logic [mfek_pkg::CSUM_BITS-1:0] csum_reg;
    logic [mfek_pkg::CSUM_BITS:0]   csum_sum;
    logic                           anti_reg;

    // divider
    logic [mfek_pkg::DVD_BITS-1:0]  dvd_reg, quo_reg;
    logic [mfek_pkg::FLOW_BITS-1:0] rem_reg;
    logic [mfek_pkg::FLOW_BITS:0]   rem_sh;
    logic                           div_ge;
    logic [mfek_pkg::DCNT_W-1:0]    dcnt_reg;

    logic m_valid_reg;
    mfek_pkg::out_word_t m_data_reg;

    assign par_w = parent_reg[w_reg];

    // ---- stores ----
    assign cap_waddr = {s_data.from_node, s_data.to_node};
    always_comb begin
        if (cmd.copy_rd)    cap_raddr = cp_reg;
        else if (cmd.rec_b) cap_raddr = {rv_reg, ru_reg};
        else                cap_raddr = {ru_reg, rv_reg};
    end

    mfek_ram #(.WIDTH(mfek_pkg::CAP_BITS), .DEPTH(mfek_pkg::SLOTS)) u_cap_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (cap_waddr),
        .wdata (s_data.edge_capacity),
        .raddr (cap_raddr),
        .rdata (cap_q)
    );

    mfek_ram #(.WIDTH(mfek_pkg::COST_BITS), .DEPTH(mfek_pkg::SLOTS)) u_cost_ram (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (cap_waddr),
        .wdata (s_data.unit_cost),
        .raddr (cap_raddr),
        .rdata (cost_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.out_load) begin
            valid_reg <= '0;
        end else if (cmd.load) begin
            valid_reg[cap_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cap_v_reg <= valid_reg[cap_raddr];
    end

    assign cap_eff  = cap_v_reg ? cap_q  : '0;
    assign cost_eff = cap_v_reg ? cost_q : '0;

    always_comb begin
        if (cmd.scan_issue)   res_raddr = {u_reg, sv_reg};
        else if (cmd.rec_a)   res_raddr = {ru_reg, rv_reg};
        else if (cmd.aug_sub) res_raddr = {w_reg, par_w};
        else                  res_raddr = {par_w, w_reg};
    end

    assign res_we = cp_pend_reg | cmd.aug_sub | cmd.aug_add;
    always_comb begin
        if (cp_pend_reg) begin
            res_waddr = cp_d_reg;
            res_wdata = {1'b0, cap_eff};
        end else if (cmd.aug_sub) begin
            res_waddr = {par_w, w_reg};
            res_wdata = res_q - {1'b0, bn_reg};
        end else begin
            res_waddr = {w_reg, par_w};
            res_wdata = res_q + {1'b0, bn_reg};
        end
    end

    mfek_ram #(.WIDTH(mfek_pkg::RES_BITS), .DEPTH(mfek_pkg::SLOTS)) u_res_ram (
        .aclk  (aclk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_q)
    );

    // ---- copy sweep ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_reg      <= '0;
            cp_pend_reg <= 1'b0;
        end else begin
            cp_pend_reg <= cmd.copy_rd;
            if (cmd.copy_rd) cp_reg <= cp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cp_d_reg <= cp_reg;
    end

    // ---- breadth-first search ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            pend_reg    <= 1'b0;
        end else begin
            pend_reg <= cmd.scan_issue;
            if (cmd.bfs_init) begin
                visited_reg <= {{(mfek_pkg::MAX_VERTICES-1){1'b0}}, 1'b1} << src_reg;
                head_reg <= '0;
                tail_reg <= (VW+1)'(1);
            end else begin
                if (cmd.pop) head_reg <= head_reg + 1'b1;
                if (pend_reg && !visited_reg[pv_reg] && res_q != '0) begin
                    visited_reg[pv_reg] <= 1'b1;
                    if (tail_reg < (VW+1)'(mfek_pkg::MAX_VERTICES)) begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bfs_init) begin
            queue_reg[0] <= src_reg;
        end else if (pend_reg && !visited_reg[pv_reg] && res_q != '0) begin
            parent_reg[pv_reg] <= u_reg;
            if (tail_reg < (VW+1)'(mfek_pkg::MAX_VERTICES)) begin
                queue_reg[tail_reg[VW-1:0]] <= pv_reg;
            end
        end
        if (cmd.pop) begin
            u_reg  <= queue_reg[head_reg[VW-1:0]];
            sv_reg <= '0;
        end else if (cmd.scan_issue) begin
            sv_reg <= sv_reg + 1'b1;
        end
        pv_reg <= sv_reg;
    end

    // ---- bottleneck and augmentation ----
    assign flow_sum = {1'b0, flow_reg} + (mfek_pkg::FLOW_BITS+1)'(bn_reg);

    always_ff @(posedge aclk) begin
        if (cmd.bn_init || cmd.aug_init) begin
            w_reg <= snk_reg;
        end else if (cmd.bn_cmp || cmd.aug_add) begin
            w_reg <= par_w;
        end
        if (cmd.bn_init) begin
            bn_reg <= mfek_pkg::PATH_CAP;
        end else if (cmd.bn_cmp && res_q < {1'b0, bn_reg}) begin
            bn_reg <= res_q[mfek_pkg::CAP_BITS-1:0];
        end
    end

    // ---- flow recovery and cost sum ----
    assign f_val    = (r_reg < {1'b0, c_reg}) ? c_reg - r_reg[mfek_pkg::CAP_BITS-1:0] : '0;
    assign csum_sum = {1'b0, csum_reg} + (mfek_pkg::CSUM_BITS+1)'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_reg <= '0;
            csum_reg <= '0;
            anti_reg <= 1'b0;
            ru_reg   <= '0;
            rv_reg   <= '0;
        end else begin
            if (cmd.copy_rd) begin
                flow_reg <= '0;
                csum_reg <= '0;
                anti_reg <= 1'b0;
                ru_reg   <= '0;
                rv_reg   <= '0;
            end
            if (cmd.aug_done) begin
                flow_reg <= (flow_sum > (mfek_pkg::FLOW_BITS+1)'(mfek_pkg::FLOW_MAX)) ?
                            mfek_pkg::FLOW_MAX : flow_sum[mfek_pkg::FLOW_BITS-1:0];
            end
            if (cmd.rec_c && c_reg != '0 && cap_eff != '0) anti_reg <= 1'b1;
            if (cmd.rec_d) begin
                csum_reg <= (csum_sum > (mfek_pkg::CSUM_BITS+1)'(mfek_pkg::CSUM_MAX)) ?
                            mfek_pkg::CSUM_MAX : csum_sum[mfek_pkg::CSUM_BITS-1:0];
                if (rv_reg == n_m1) begin
                    rv_reg <= '0;
                    ru_reg <= ru_reg + 1'b1;
                end else begin
                    rv_reg <= rv_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rec_b) begin
            c_reg  <= cap_eff;
            uc_reg <= cost_eff;
            r_reg  <= res_q;
        end
        if (cmd.rec_c) begin
            // pairs with both directions loaded add no cost
            prod_reg <= (c_reg != '0 && cap_eff == '0) ?
                        mfek_pkg::PROD_BITS'(f_val) * mfek_pkg::PROD_BITS'(uc_reg) : '0;
        end
    end

    // ---- restoring divider, one quotient bit a cycle ----
    assign rem_sh = {rem_reg, dvd_reg[mfek_pkg::DVD_BITS-1]};
    assign div_ge = rem_sh >= {1'b0, flow_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dvd_reg  <= {csum_reg, {mfek_pkg::FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= mfek_pkg::DIV_STEPS;
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[mfek_pkg::DVD_BITS-2:0], 1'b0};
            rem_reg  <= div_ge ? mfek_pkg::FLOW_BITS'(rem_sh - {1'b0, flow_reg}) :
                                 rem_sh[mfek_pkg::FLOW_BITS-1:0];
            quo_reg  <= {quo_reg[mfek_pkg::DVD_BITS-2:0], div_ge};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.total_flow <= flow_reg;
            m_data_reg.total_cost <= csum_reg;
            m_data_reg.avg_cost   <= (quo_reg > mfek_pkg::DVD_BITS'(mfek_pkg::AVG_MAX)) ?
                                     mfek_pkg::AVG_MAX : quo_reg[mfek_pkg::AVG_BITS-1:0];
            if (anti_reg)            m_data_reg.status <= mfek_pkg::STATUS_ANTIPARALLEL;
            else if (flow_reg == '0) m_data_reg.status <= mfek_pkg::STATUS_ZERO_FLOW;
            else                     m_data_reg.status <= mfek_pkg::STATUS_OK;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---- status to controller ----
    assign stat.cp_last    = (cp_reg == '1);
    assign stat.terms_ok   = ({1'b0, src_reg} < n_eff) && ({1'b0, snk_reg} < n_eff) &&
                             (src_reg != snk_reg);
    assign stat.n_zero     = (n_eff == '0);
    assign stat.q_empty    = (head_reg == tail_reg);
    assign stat.scan_last  = (sv_reg == n_m1);
    assign stat.sink_found = visited_reg[snk_reg];
    assign stat.path_done  = (w_reg == src_reg);
    assign stat.rec_last   = (ru_reg == n_m1) && (rv_reg == n_m1);
    assign stat.flow_zero  = (flow_reg == '0);
    assign stat.div_last   = (dcnt_reg == mfek_pkg::DCNT_W'(1));
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

// File: design/max_flow_edmonds_karp_core.sv
// Non-final edge words load one per cycle.
// Final edge: a copy of all 256 slots into the residual store, then per search a scan of
// each dequeued vertex, a bottleneck pass and an update pass per path hop, flow recovery
// over all n*n vertex pairs and a division; searches and recovery usually dominate.
// Input is held off during the run; the result word waits in an output register.
// Synchronous active-low reset clears control state and all slot valid bits at once.
module max_flow_edmonds_karp_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mfek_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mfek_pkg::out_word_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [mfek_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfek_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    mfek_pkg::cmd_t  cmd;
    mfek_pkg::stat_t stat;

    mfek_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_edge),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    mfek_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
